@@ hdl/pga_pkg.sv @@
package pga_pkg;

  // Default geometry and vertex limit
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_BITS_DEF   = 16;

  // Fixed arithmetic widths of the shoelace sum and the reported area
  localparam int CROSS_BITS   = 43;
  localparam int AREA_BITS    = 42;
  localparam int MIN_VERTICES = 3;

endpackage

@@ hdl/pga_vertex_if.sv @@
interface pga_vertex_if #(
  parameter int COORD_BITS = pga_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         is_last;

  modport source (output valid, vertex_x, vertex_y, is_last, input ready);
  modport sink   (input valid, vertex_x, vertex_y, is_last, output ready);
endinterface

@@ hdl/pga_result_if.sv @@
interface pga_result_if #(
  parameter int MAX_VERTICES = pga_pkg::MAX_VERTICES_DEF
);
  localparam int TOTAL_BITS = $clog2(MAX_VERTICES + 1);

  logic                           valid;
  logic                           ready;
  logic [pga_pkg::AREA_BITS-1:0]  double_area;
  logic                           has_right_angle;
  logic [TOTAL_BITS-1:0]          vertex_total;
  logic                           overflowed;

  modport source (output valid, double_area, has_right_angle, vertex_total, overflowed,
                  input ready);
  modport sink   (input valid, double_area, has_right_angle, vertex_total, overflowed,
                  output ready);
endinterface

@@ hdl/pga_in_reg.sv @@
module pga_in_reg (
  input  logic         clk,
  input  logic         rst,
  pga_vertex_if.sink   up,
  pga_vertex_if.source down
);

  logic valid;

  // Load whenever the stage is empty or its transaction moves on this cycle
  assign up.ready   = !valid || down.ready;
  assign down.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up.ready) begin
      valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.ready && up.valid) begin
      down.vertex_x <= up.vertex_x;
      down.vertex_y <= up.vertex_y;
      down.is_last  <= up.is_last;
    end
  end

endmodule

@@ hdl/pga_core.sv @@
module pga_core #(
  parameter int MAX_VERTICES = pga_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pga_pkg::COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pga_vertex_if.sink   vin,
  pga_result_if.source res
);

  localparam int C      = COORD_BITS;
  localparam int CB     = pga_pkg::CROSS_BITS;
  localparam int AB     = pga_pkg::AREA_BITS;
  localparam int TW     = $clog2(MAX_VERTICES + 1);
  localparam int PW     = 2 * C;
  localparam int WIDE   = (PW + 1 > CB) ? PW + 1 : CB;
  localparam int DW     = C + 1;
  localparam int DPW    = 2 * DW;
  localparam int DSW    = DPW + 1;

  // ax*by - bx*ay, wrapped to the width of the running sum
  function automatic logic [CB-1:0] cross_term(
    input logic signed [C-1:0] ax, input logic signed [C-1:0] ay,
    input logic signed [C-1:0] bx, input logic signed [C-1:0] by
  );
    logic signed [PW-1:0]   pa;
    logic signed [PW-1:0]   pb;
    logic signed [WIDE-1:0] t;
    pa = ax * by;
    pb = bx * ay;
    t  = WIDE'(pa) - WIDE'(pb);
    return t[CB-1:0];
  endfunction

  // Corner at b: edges a->b and b->c are perpendicular
  function automatic logic is_right(
    input logic signed [C-1:0] ax, input logic signed [C-1:0] ay,
    input logic signed [C-1:0] bx, input logic signed [C-1:0] by,
    input logic signed [C-1:0] cx, input logic signed [C-1:0] cy
  );
    logic signed [DW-1:0]  d1x;
    logic signed [DW-1:0]  d1y;
    logic signed [DW-1:0]  d2x;
    logic signed [DW-1:0]  d2y;
    logic signed [DPW-1:0] p;
    logic signed [DPW-1:0] q;
    logic signed [DSW-1:0] s;
    d1x = DW'(bx) - DW'(ax);
    d1y = DW'(by) - DW'(ay);
    d2x = DW'(cx) - DW'(bx);
    d2y = DW'(cy) - DW'(by);
    p   = d1x * d2x;
    q   = d1y * d2y;
    s   = DSW'(p) + DSW'(q);
    return s == '0;
  endfunction

  logic signed [C-1:0] first_vx, first_vy, second_vx, second_vy;
  logic signed [C-1:0] prev_vx, prev_vy, older_vx, older_vy;
  logic [CB-1:0]       cross_sum;
  logic                angle_found;
  logic [TW-1:0]       seen_count;
  logic                overflow_seen;

  logic                out_valid;
  logic                can_out;
  logic                fire;

  logic [CB-1:0]       sum_next;
  logic                angle_found_next;
  logic [TW-1:0]       seen_count_next;
  logic                overflow_seen_next;
  logic                at_limit;
  logic [CB-1:0]       closed_sum;
  logic [CB-1:0]       magnitude;
  logic [AB-1:0]       area;
  logic                enough;
  logic                right_any;

  assign can_out   = !out_valid || res.ready;
  // Only a closing vertex needs room in the result register
  assign vin.ready = !vin.is_last || can_out;
  assign fire      = vin.valid && vin.ready;
  assign res.valid = out_valid;

  always_comb begin
    at_limit = seen_count >= TW'(MAX_VERTICES);

    sum_next = cross_sum;
    if (seen_count != '0) begin
      sum_next = cross_sum + cross_term(prev_vx, prev_vy, vin.vertex_x, vin.vertex_y);
    end

    angle_found_next = angle_found;
    if (seen_count >= TW'(2)) begin
      angle_found_next = angle_found |
                         is_right(older_vx, older_vy, prev_vx, prev_vy,
                                  vin.vertex_x, vin.vertex_y);
    end

    seen_count_next    = at_limit ? seen_count : seen_count + TW'(1);
    overflow_seen_next = overflow_seen | at_limit;

    // Closing edge and the two wrap-around corners
    closed_sum = sum_next + cross_term(vin.vertex_x, vin.vertex_y, first_vx, first_vy);
    right_any  = angle_found_next |
                 is_right(prev_vx, prev_vy, vin.vertex_x, vin.vertex_y,
                          first_vx, first_vy) |
                 is_right(vin.vertex_x, vin.vertex_y, first_vx, first_vy,
                          second_vx, second_vy);

    magnitude = closed_sum[CB-1] ? (~closed_sum + CB'(1)) : closed_sum;
    area      = magnitude[CB-1] ? {AB{1'b1}} : magnitude[AB-1:0];
    enough    = seen_count_next >= TW'(pga_pkg::MIN_VERTICES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cross_sum     <= '0;
      angle_found   <= 1'b0;
      seen_count    <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (fire && vin.is_last) begin
        // Clear the polygon state for the next one
        cross_sum     <= '0;
        angle_found   <= 1'b0;
        seen_count    <= '0;
        overflow_seen <= 1'b0;
      end else if (fire) begin
        cross_sum     <= sum_next;
        angle_found   <= angle_found_next;
        seen_count    <= seen_count_next;
        overflow_seen <= overflow_seen_next;
      end

      if (fire && vin.is_last) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (seen_count == '0) begin
        first_vx <= vin.vertex_x;
        first_vy <= vin.vertex_y;
      end
      if (seen_count == TW'(1)) begin
        second_vx <= vin.vertex_x;
        second_vy <= vin.vertex_y;
      end
      older_vx <= prev_vx;
      older_vy <= prev_vy;
      prev_vx  <= vin.vertex_x;
      prev_vy  <= vin.vertex_y;
    end
    if (fire && vin.is_last) begin
      res.double_area     <= enough ? area : '0;
      res.has_right_angle <= enough & right_any;
      res.vertex_total    <= seen_count_next;
      res.overflowed      <= overflow_seen_next;
    end
  end

endmodule

@@ hdl/polygon_area_right_angle_top.sv @@
// Shoelace polygon area with right-angle detection.
//
// vertex: one transaction per polygon vertex (vertex_x, vertex_y, is_last),
//   the final vertex of a polygon marked with is_last.
// result: one transaction per polygon, sent for the vertex marked is_last:
//   double_area (twice the absolute area, saturating), has_right_angle,
//   vertex_total (saturating at MAX_VERTICES) and overflowed. Polygons of
//   fewer than three vertices report zero area and no right angle.
//
// Throughput: one vertex per cycle, except that a closing vertex waits
// while a result is held. Each vertex passes an input register, then one
// step of cross products, corner dot products and the running sum that
// loads the result register.
//
// Reset (rst, synchronous) empties both registers and clears the polygon
// in progress. While the receiver stalls, the result is held; ordinary
// vertices keep flowing, and the next closing vertex waits until the held
// result has been taken.
module polygon_area_right_angle_top #(
  parameter int MAX_VERTICES = pga_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pga_pkg::COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pga_vertex_if.sink   vertex,
  pga_result_if.source result
);

  pga_vertex_if #(.COORD_BITS(COORD_BITS)) staged ();

  pga_in_reg u_in_reg (
    .clk  (clk),
    .rst  (rst),
    .up   (vertex),
    .down (staged)
  );

  pga_core #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .vin (staged),
    .res (result)
  );

endmodule

@@ sim/polygon_area_right_angle_top_tb.sv @@
`timescale 1ns / 1ps

module polygon_area_right_angle_top_tb;

  localparam int MAX_V      = pga_pkg::MAX_VERTICES_DEF;
  localparam int COORD_W    = pga_pkg::COORD_BITS_DEF;
  localparam int CROSS_W    = pga_pkg::CROSS_BITS;
  localparam int AREA_W     = pga_pkg::AREA_BITS;
  localparam int MIN_V      = pga_pkg::MIN_VERTICES;
  localparam int TOTAL_W    = $clog2(MAX_V + 1);
  localparam int RANDOM_ITEMS = 510;
  localparam int WATCHDOG   = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [AREA_W-1:0]  double_area;
    logic               has_right_angle;
    logic [TOTAL_W-1:0] vertex_total;
    logic               overflowed;
  } poly_result_t;

  typedef enum int {STY_FULL, STY_GRID, STY_EXTREME, STY_RECT} shape_style_t;

  class area_scoreboard;
    longint first_x, first_y, second_x, second_y;
    longint prev_x, prev_y, older_x, older_y;
    logic [CROSS_W-1:0] shoelace_sum;
    bit corner_hit;
    bit count_sat;
    int unsigned vertex_count;
    poly_result_t expected_q[$];
    int unsigned mismatches;
    int unsigned polygons;
    int unsigned right_polys;
    int unsigned overflow_polys;
    int unsigned vertices;

    function new();
      clear();
      mismatches = 0;
      polygons = 0;
      right_polys = 0;
      overflow_polys = 0;
      vertices = 0;
    endfunction

    function void clear();
      first_x = 0; first_y = 0; second_x = 0; second_y = 0;
      prev_x = 0; prev_y = 0; older_x = 0; older_y = 0;
      shoelace_sum = '0;
      corner_hit = 1'b0;
      count_sat = 1'b0;
      vertex_count = 0;
    endfunction

    function void add_term(longint ax, longint ay, longint bx, longint by);
      logic [63:0] t;
      t = ax * by - bx * ay;
      shoelace_sum = shoelace_sum + t[CROSS_W-1:0];
    endfunction

    // corner at b, edges a->b and b->c
    function bit square_corner(longint ax, longint ay, longint bx, longint by,
                               longint cx, longint cy);
      return ((bx - ax) * (cx - bx)) == -((by - ay) * (cy - by));
    endfunction

    function void note_vertex(coord_t vx, coord_t vy, bit last);
      longint x;
      longint y;
      logic [CROSS_W-1:0] mag;
      poly_result_t r;
      x = vx;
      y = vy;
      vertices++;
      if (vertex_count == 0) begin
        first_x = x; first_y = y;
      end else if (vertex_count == 1) begin
        second_x = x; second_y = y;
        add_term(prev_x, prev_y, x, y);
      end else begin
        add_term(prev_x, prev_y, x, y);
        if (square_corner(older_x, older_y, prev_x, prev_y, x, y)) corner_hit = 1'b1;
      end
      if (vertex_count >= MAX_V) count_sat = 1'b1;
      else vertex_count++;
      older_x = prev_x; older_y = prev_y;
      prev_x = x; prev_y = y;
      if (!last) return;

      r = '0;
      if (vertex_count >= MIN_V) begin
        // close the ring and check the two corners that wrap round
        add_term(x, y, first_x, first_y);
        if (square_corner(older_x, older_y, x, y, first_x, first_y)) corner_hit = 1'b1;
        if (square_corner(x, y, first_x, first_y, second_x, second_y)) corner_hit = 1'b1;
        mag = shoelace_sum;
        if (mag[CROSS_W-1]) mag = -mag;
        if (mag[CROSS_W-1:AREA_W] != '0) r.double_area = '1;
        else r.double_area = mag[AREA_W-1:0];
        r.has_right_angle = corner_hit;
      end
      r.vertex_total = vertex_count[TOTAL_W-1:0];
      r.overflowed = count_sat;
      expected_q.push_back(r);
      polygons++;
      if (r.has_right_angle) right_polys++;
      if (r.overflowed) overflow_polys++;
      clear();
    endfunction

    function void check_result(poly_result_t got);
      poly_result_t want;
      if (expected_q.size() == 0) begin
        $error("result transaction with no polygon pending");
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.double_area !== want.double_area) begin
        $error("double_area: expected %0d, got %0d", want.double_area, got.double_area);
        mismatches++;
      end
      if (got.has_right_angle !== want.has_right_angle) begin
        $error("has_right_angle: expected %0d, got %0d",
               want.has_right_angle, got.has_right_angle);
        mismatches++;
      end
      if (got.vertex_total !== want.vertex_total) begin
        $error("vertex_total: expected %0d, got %0d", want.vertex_total, got.vertex_total);
        mismatches++;
      end
      if (got.overflowed !== want.overflowed) begin
        $error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  pga_vertex_if #(.COORD_BITS(COORD_W)) vertex_ch ();
  pga_result_if #(.MAX_VERTICES(MAX_V)) result_ch ();

  polygon_area_right_angle_top #(
    .MAX_VERTICES(MAX_V),
    .COORD_BITS  (COORD_W)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .vertex(vertex_ch),
    .result(result_ch)
  );

  area_scoreboard sb = new();

  int sender_idle_pct;
  int recv_stall_pct;
  int unsigned vertices_sent = 0;
  int unsigned quiet_cycles = 0;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor both channels and watch for a stalled run
  always @(posedge clk) begin
    poly_result_t got;
    got.double_area     = result_ch.double_area;
    got.has_right_angle = result_ch.has_right_angle;
    got.vertex_total    = result_ch.vertex_total;
    got.overflowed      = result_ch.overflowed;
    if (vertex_ch.valid && vertex_ch.ready)
      sb.note_vertex(vertex_ch.vertex_x, vertex_ch.vertex_y, vertex_ch.is_last);
    if (result_ch.valid && result_ch.ready)
      sb.check_result(got);
    if ((vertex_ch.valid && vertex_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_vertex(input coord_t x, input coord_t y, input bit last);
    while ($urandom_range(99) < sender_idle_pct) begin
      vertex_ch.valid <= 1'b0;
      @(posedge clk);
    end
    vertex_ch.valid    <= 1'b1;
    vertex_ch.vertex_x <= x;
    vertex_ch.vertex_y <= y;
    vertex_ch.is_last  <= last;
    @(posedge clk);
    while (!vertex_ch.ready) @(posedge clk);
    vertices_sent++;
  endtask

  function automatic coord_t rand_coord(shape_style_t style);
    case (style)
      STY_GRID: return coord_t'(int'($urandom_range(6)) - 3);
      STY_EXTREME: begin
        case ($urandom_range(5))
          0: return coord_t'(16'h8000);
          1: return coord_t'(16'h8001);
          2: return coord_t'(-1);
          3: return coord_t'(0);
          4: return coord_t'(1);
          default: return coord_t'(16'h7fff);
        endcase
      end
      default: return coord_t'($urandom_range(16'hffff));
    endcase
  endfunction

  task automatic send_polygon(input int unsigned n, input shape_style_t style);
    coord_t x;
    coord_t y;
    x = rand_coord(style);
    y = rand_coord(style);
    for (int unsigned i = 0; i < n; i++) begin
      if (i != 0) begin
        // rectilinear walks alternate the axis they move along
        if (style == STY_RECT) begin
          if (i % 2) x = rand_coord(STY_FULL);
          else y = rand_coord(STY_FULL);
        end else begin
          x = rand_coord(style);
          y = rand_coord(style);
        end
      end
      send_vertex(x, y, i == n - 1);
    end
  endtask

  task automatic send_tri(input int x0, input int y0, input int x1,
                          input int y1, input int x2, input int y2);
    send_vertex(coord_t'(x0), coord_t'(y0), 1'b0);
    send_vertex(coord_t'(x1), coord_t'(y1), 1'b0);
    send_vertex(coord_t'(x2), coord_t'(y2), 1'b1);
  endtask

  // Full-range square, walked round repeatedly to build up a large sum
  task automatic send_square_loops(input int unsigned loops, input bit reverse);
    coord_t lo;
    coord_t hi;
    lo = coord_t'(16'h8000);
    hi = coord_t'(16'h7fff);
    for (int unsigned k = 0; k < loops; k++) begin
      send_vertex(lo, lo, 1'b0);
      if (reverse) send_vertex(lo, hi, 1'b0);
      else send_vertex(hi, lo, 1'b0);
      send_vertex(hi, hi, 1'b0);
      if (reverse) send_vertex(hi, lo, k == loops - 1);
      else send_vertex(lo, hi, k == loops - 1);
    end
  endtask

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(2, 1);
    if (r < 85) return $urandom_range(10, 3);
    return $urandom_range(40, 11);
  endfunction

  initial begin
    int unsigned base;
    rst                <= 1'b1;
    vertex_ch.valid    <= 1'b0;
    vertex_ch.vertex_x <= '0;
    vertex_ch.vertex_y <= '0;
    vertex_ch.is_last  <= 1'b0;
    sender_idle_pct = 17;
    recv_stall_pct  = 79;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Degenerate polygons: one and two vertices
    send_vertex(coord_t'(16'h7fff), coord_t'(16'h8000), 1'b1);
    send_vertex(coord_t'(16'h8000), coord_t'(16'h7fff), 1'b0);
    send_vertex(coord_t'(5), coord_t'(-7), 1'b1);
    // Right angle at the middle, at the closing vertex and at the first; then none
    send_tri(0, 3, 0, 0, 4, 0);
    send_tri(4, 0, 0, 3, 0, 0);
    send_tri(0, 0, 4, 0, 0, 3);
    send_tri(0, 0, 5, 1, 2, 7);
    // Coincident points give zero edges, hence a zero dot product
    send_tri(-9, 9, -9, 9, -9, 9);
    send_square_loops(1, 1'b0);
    send_square_loops(1, 1'b1);
    // Long polygon with a large running sum
    send_square_loops(40, 1'b0);

    base = vertices_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 17; recv_stall_pct = 79; end
        1: begin sender_idle_pct = 79; recv_stall_pct = 17; end
        default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      while (vertices_sent - base < (phase + 1) * RANDOM_ITEMS / 3)
        send_polygon(pick_size(), shape_style_t'($urandom_range(3)));
    end
    vertex_ch.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d vertices in %0d polygons, %0d with a right angle, %0d past the limit",
             sb.vertices, sb.polygons, sb.right_polys, sb.overflow_polys);
    $display("summary: %0d field mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
